[src/ffra_pkg.sv]
// Package with types, codes and defaults of the first-fit range allocator.
package ffra_pkg;

	localparam int unsigned MAX_SECTIONS_DEF = 64;
	localparam int unsigned OFFSET_BITS_DEF  = 32;
	localparam logic [31:0] HEAP_SIZE_RST    = 32'd67108864;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_RD,
		S_ALIGN,
		S_EVAL,
		S_SH_RD,
		S_SH_WR,
		S_FIN1,
		S_FIN2,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC   = 1'b0,
		MODE_RELEASE = 1'b1
	} mode_t;

endpackage

[src/first_fit_range_allocator.sv]
// First-fit range allocator: sorted free list in one memory, walked by a small sequencer.
//
// The free list lives in a single-port-read, single-port-write memory of MAX_SECTIONS entries,
// and one sequencer walks it an entry at a time. For each free range scanned, an allocate
// request reads it, aligns it and checks the fit; a release request reads it and compares it.
// A request that splits a range or inserts a new one moves every later entry up by one slot,
// and a request that removes a range moves every later entry down by one; each moved entry is
// read and then written. Up to two final writes follow, then the result is loaded into the
// output register once any earlier result there has been taken; the next request can be taken
// in the cycle after that. The input side is stalled for the whole of a request; a finished
// result may wait in the output register while the next request is taken. After reset, and
// after each write of heap_size, the list is rebuilt in the S_INIT step, during which input is
// stalled, as one range [0, heap_size), or as an empty list when heap_size is zero.
module first_fit_range_allocator
	import ffra_pkg::*;
#(
	parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF,
	parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] req_size,
	input  logic [31:0] req_alignment,
	input  logic [31:0] rel_begin,
	input  logic [31:0] rel_end,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] offset
);

	localparam int unsigned IW = $clog2(MAX_SECTIONS);
	localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);
	localparam int unsigned OB = OFFSET_BITS;
	localparam int unsigned WW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
	localparam int unsigned DW = 2 * OFFSET_BITS;

	// control state
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [31:0]     heap_q;
	logic            out_valid_q, out_valid_d;

	// datapath state
	mode_t           mode_q, mode_d;
	logic [31:0]     size_q, size_d;
	logic [31:0]     am_q, am_d;
	logic [OB-1:0]   b_q, b_d;
	logic [OB-1:0]   e_q, e_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [WW-1:0]   ab_q, ab_d;
	logic [OB-1:0]   prev_b_q, prev_b_d;
	logic [OB-1:0]   prev_e_q, prev_e_d;
	logic [CW-1:0]   sh_src_q, sh_src_d;
	logic            sh_up_q, sh_up_d;
	logic [CW-1:0]   sh_lo_q, sh_lo_d;
	logic            f0_vld_q, f0_vld_d;
	logic [IW-1:0]   f0_addr_q, f0_addr_d;
	logic [DW-1:0]   f0_data_q, f0_data_d;
	logic            f1_vld_q, f1_vld_d;
	logic [IW-1:0]   f1_addr_q, f1_addr_d;
	logic [DW-1:0]   f1_data_q, f1_data_d;
	logic [CW-1:0]   cnt_new_q, cnt_new_d;
	status_t         st_q, st_d;
	logic [31:0]     off_q, off_d;
	status_t         status_q, status_d;
	logic [31:0]     offset_q, offset_d;

	// free list memory
	logic [DW-1:0]   mem [MAX_SECTIONS];
	logic [DW-1:0]   rd_q;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	logic [DW-1:0]   mem_wdata;

	// shared datapath
	logic [63:0]     heap_ext, relb_ext, rele_ext;
	logic [OB-1:0]   heap_m, in_b, in_e;
	logic [OB-1:0]   cur_b, cur_e;
	logic [WW-1:0]   ab_calc, ae_calc;
	logic            full, idx_last;
	logic [CW-1:0]   cnt_m1, idx_p1;

	assign heap_ext = {32'd0, heap_q};
	assign relb_ext = {32'd0, rel_begin};
	assign rele_ext = {32'd0, rel_end};
	assign heap_m   = heap_ext[OB-1:0];
	assign in_b     = relb_ext[OB-1:0];
	assign in_e     = rele_ext[OB-1:0];
	assign cur_b    = rd_q[DW-1:OB];
	assign cur_e    = rd_q[OB-1:0];
	assign ab_calc  = (WW'(cur_b) + WW'(am_q)) & ~WW'(am_q);
	assign ae_calc  = ab_q + WW'(size_q);
	assign full     = (cnt_q == CW'(MAX_SECTIONS));
	assign cnt_m1   = cnt_q - CW'(1);
	assign idx_p1   = idx_q + CW'(1);
	assign idx_last = (idx_p1 == cnt_q);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign offset    = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			heap_q      <= HEAP_SIZE_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				heap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q    <= mode_d;
		size_q    <= size_d;
		am_q      <= am_d;
		b_q       <= b_d;
		e_q       <= e_d;
		idx_q     <= idx_d;
		ab_q      <= ab_d;
		prev_b_q  <= prev_b_d;
		prev_e_q  <= prev_e_d;
		sh_src_q  <= sh_src_d;
		sh_up_q   <= sh_up_d;
		sh_lo_q   <= sh_lo_d;
		f0_vld_q  <= f0_vld_d;
		f0_addr_q <= f0_addr_d;
		f0_data_q <= f0_data_d;
		f1_vld_q  <= f1_vld_d;
		f1_addr_q <= f1_addr_d;
		f1_data_q <= f1_data_d;
		cnt_new_q <= cnt_new_d;
		st_q      <= st_d;
		off_q     <= off_d;
		status_q  <= status_d;
		offset_q  <= offset_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && out_stall;
		mode_d      = mode_q;
		size_d      = size_q;
		am_d        = am_q;
		b_d         = b_q;
		e_d         = e_q;
		idx_d       = idx_q;
		ab_d        = ab_q;
		prev_b_d    = prev_b_q;
		prev_e_d    = prev_e_q;
		sh_src_d    = sh_src_q;
		sh_up_d     = sh_up_q;
		sh_lo_d     = sh_lo_q;
		f0_vld_d    = f0_vld_q;
		f0_addr_d   = f0_addr_q;
		f0_data_d   = f0_data_q;
		f1_vld_d    = f1_vld_q;
		f1_addr_d   = f1_addr_q;
		f1_data_d   = f1_data_q;
		cnt_new_d   = cnt_new_q;
		st_d        = st_q;
		off_d       = off_q;
		status_d    = status_q;
		offset_d    = offset_q;
		mem_we      = 1'b0;
		mem_waddr   = f0_addr_q;
		mem_wdata   = f0_data_q;
		mem_raddr   = idx_q[IW-1:0];

		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {{OB{1'b0}}, heap_m};
				cnt_d     = (heap_m != '0) ? CW'(1) : '0;
				state_d   = S_IDLE;
			end

			S_IDLE: begin
				if (in_valid) begin
					mode_d   = mode_t'(mode);
					size_d   = req_size;
					am_d     = (req_alignment == 32'd0) ? 32'd0
						: (~req_alignment & (req_alignment - 32'd1));
					b_d      = in_b;
					e_d      = in_e;
					idx_d    = '0;
					st_d     = ST_DONE;
					off_d    = 32'd0;
					f0_vld_d = 1'b0;
					f1_vld_d = 1'b0;
					if (mode_t'(mode) == MODE_ALLOC) begin
						if (req_size == 32'd0 || cnt_q == '0) begin
							st_d    = ST_NOFIT;
							state_d = S_RESP;
						end else begin
							state_d = S_RD;
						end
					end else if (in_e <= in_b) begin
						state_d = S_RESP;
					end else if (cnt_q == '0) begin
						f0_vld_d  = 1'b1;
						f0_addr_d = '0;
						f0_data_d = {in_b, in_e};
						cnt_new_d = CW'(1);
						state_d   = S_FIN1;
					end else begin
						state_d = S_RD;
					end
				end
			end

			S_RD: begin
				mem_raddr = idx_q[IW-1:0];
				state_d   = (mode_q == MODE_ALLOC) ? S_ALIGN : S_EVAL;
			end

			S_ALIGN: begin
				ab_d    = ab_calc;
				state_d = S_EVAL;
			end

			S_EVAL: begin
				if (mode_q == MODE_ALLOC) begin
					if (ae_calc > WW'(cur_e)) begin
						if (idx_last) begin
							st_d    = ST_NOFIT;
							state_d = S_RESP;
						end else begin
							idx_d   = idx_p1;
							state_d = S_RD;
						end
					end else if (ab_q > WW'(cur_b) && ae_calc < WW'(cur_e)) begin
						if (full) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else begin
							off_d     = ab_q[31:0];
							f0_vld_d  = 1'b1;
							f0_addr_d = idx_q[IW-1:0];
							f0_data_d = {cur_b, ab_q[OB-1:0]};
							f1_vld_d  = 1'b1;
							f1_addr_d = IW'(idx_p1);
							f1_data_d = {ae_calc[OB-1:0], cur_e};
							cnt_new_d = cnt_q + CW'(1);
							sh_up_d   = 1'b1;
							sh_lo_d   = idx_p1;
							sh_src_d  = cnt_m1;
							state_d   = (idx_p1 >= cnt_q) ? S_FIN1 : S_SH_RD;
						end
					end else if (ab_q > WW'(cur_b)) begin
						off_d     = ab_q[31:0];
						f0_vld_d  = 1'b1;
						f0_addr_d = idx_q[IW-1:0];
						f0_data_d = {cur_b, ab_q[OB-1:0]};
						cnt_new_d = cnt_q;
						state_d   = S_FIN1;
					end else if (ae_calc < WW'(cur_e)) begin
						off_d     = ab_q[31:0];
						f0_vld_d  = 1'b1;
						f0_addr_d = idx_q[IW-1:0];
						f0_data_d = {ae_calc[OB-1:0], cur_e};
						cnt_new_d = cnt_q;
						state_d   = S_FIN1;
					end else begin
						off_d     = ab_q[31:0];
						cnt_new_d = cnt_m1;
						sh_up_d   = 1'b0;
						sh_lo_d   = idx_p1;
						sh_src_d  = idx_p1;
						state_d   = (idx_p1 >= cnt_q) ? S_FIN1 : S_SH_RD;
					end
				end else begin
					if (cur_b < b_q) begin
						prev_b_d = cur_b;
						prev_e_d = cur_e;
						idx_d    = idx_p1;
						if (!idx_last) begin
							state_d = S_RD;
						end else if (cur_e == b_q) begin
							f0_vld_d  = 1'b1;
							f0_addr_d = idx_q[IW-1:0];
							f0_data_d = {cur_b, e_q};
							cnt_new_d = cnt_q;
							state_d   = S_FIN1;
						end else if (full) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else begin
							f0_vld_d  = 1'b1;
							f0_addr_d = cnt_q[IW-1:0];
							f0_data_d = {b_q, e_q};
							cnt_new_d = cnt_q + CW'(1);
							state_d   = S_FIN1;
						end
					end else if (idx_q == '0) begin
						if (cur_b == e_q) begin
							f0_vld_d  = 1'b1;
							f0_addr_d = '0;
							f0_data_d = {b_q, cur_e};
							cnt_new_d = cnt_q;
							state_d   = S_FIN1;
						end else if (full) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else begin
							f0_vld_d  = 1'b1;
							f0_addr_d = '0;
							f0_data_d = {b_q, e_q};
							cnt_new_d = cnt_q + CW'(1);
							sh_up_d   = 1'b1;
							sh_lo_d   = '0;
							sh_src_d  = cnt_m1;
							state_d   = S_SH_RD;
						end
					end else if (prev_e_q == b_q && cur_b == e_q) begin
						f0_vld_d  = 1'b1;
						f0_addr_d = IW'(idx_q - CW'(1));
						f0_data_d = {prev_b_q, cur_e};
						cnt_new_d = cnt_m1;
						sh_up_d   = 1'b0;
						sh_lo_d   = idx_p1;
						sh_src_d  = idx_p1;
						state_d   = (idx_p1 >= cnt_q) ? S_FIN1 : S_SH_RD;
					end else if (prev_e_q == b_q) begin
						f0_vld_d  = 1'b1;
						f0_addr_d = IW'(idx_q - CW'(1));
						f0_data_d = {prev_b_q, e_q};
						cnt_new_d = cnt_q;
						state_d   = S_FIN1;
					end else if (cur_b == e_q) begin
						f0_vld_d  = 1'b1;
						f0_addr_d = idx_q[IW-1:0];
						f0_data_d = {b_q, cur_e};
						cnt_new_d = cnt_q;
						state_d   = S_FIN1;
					end else if (full) begin
						st_d    = ST_FULL;
						state_d = S_RESP;
					end else begin
						f0_vld_d  = 1'b1;
						f0_addr_d = idx_q[IW-1:0];
						f0_data_d = {b_q, e_q};
						cnt_new_d = cnt_q + CW'(1);
						sh_up_d   = 1'b1;
						sh_lo_d   = idx_q;
						sh_src_d  = cnt_m1;
						state_d   = S_SH_RD;
					end
				end
			end

			S_SH_RD: begin
				mem_raddr = sh_src_q[IW-1:0];
				state_d   = S_SH_WR;
			end

			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_q;
				if (sh_up_q) begin
					mem_waddr = IW'(sh_src_q + CW'(1));
					if (sh_src_q == sh_lo_q) begin
						state_d = S_FIN1;
					end else begin
						sh_src_d = sh_src_q - CW'(1);
						state_d  = S_SH_RD;
					end
				end else begin
					mem_waddr = IW'(sh_src_q - CW'(1));
					if (sh_src_q == cnt_m1) begin
						state_d = S_FIN1;
					end else begin
						sh_src_d = sh_src_q + CW'(1);
						state_d  = S_SH_RD;
					end
				end
			end

			S_FIN1: begin
				mem_we    = f0_vld_q;
				mem_waddr = f0_addr_q;
				mem_wdata = f0_data_q;
				if (f1_vld_q) begin
					state_d = S_FIN2;
				end else begin
					cnt_d   = cnt_new_q;
					state_d = S_RESP;
				end
			end

			S_FIN2: begin
				mem_we    = 1'b1;
				mem_waddr = f1_addr_q;
				mem_wdata = f1_data_q;
				cnt_d     = cnt_new_q;
				state_d   = S_RESP;
			end

			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					status_d    = st_q;
					offset_d    = off_q;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_we) begin
			state_d = S_INIT;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SECTIONS))
		else $error("free count above list depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while another is in progress");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response step");

	a_cfg_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == S_INIT))
		else $error("heap size write did not rebuild the list");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_DONE) |-> (offset_q == 32'd0))
		else $error("nonzero offset on failed request");

endmodule
